@@ rtl/kfcv_pkg.sv @@
// ----------------------------------------------------------------------------
// kfcv_pkg
// Shared types, constants and fixed-point helpers for the Kalman filter.
// ----------------------------------------------------------------------------
package kfcv_pkg;

   localparam int unsigned DataWidth = 32;
   localparam int unsigned AddrWidth = 5;

   // register byte addresses
   localparam logic [AddrWidth-1:0] ADDR_TIME_STEP     = 5'd0;
   localparam logic [AddrWidth-1:0] ADDR_NOISE_POS     = 5'd4;
   localparam logic [AddrWidth-1:0] ADDR_NOISE_VEL     = 5'd8;
   localparam logic [AddrWidth-1:0] ADDR_NOISE_MEAS    = 5'd12;
   localparam logic [AddrWidth-1:0] ADDR_INIT_VAR_POS  = 5'd16;
   localparam logic [AddrWidth-1:0] ADDR_INIT_COV_CROSS = 5'd20;
   localparam logic [AddrWidth-1:0] ADDR_INIT_VAR_VEL  = 5'd24;

   localparam logic [30:0] RST_TIME_STEP = 31'd66;
   localparam logic signed [31:0] RST_NOISE_POS = -32'sd1566;
   localparam logic signed [31:0] RST_NOISE_VEL = 32'sd27853;
   localparam logic signed [31:0] RST_NOISE_MEAS = 32'sd2569;
   localparam logic signed [31:0] RST_INIT_VAR_POS = 32'sd7;
   localparam logic signed [31:0] RST_INIT_COV_CROSS = 32'sd7;
   localparam logic signed [31:0] RST_INIT_VAR_VEL = 32'sd720896;

   localparam int unsigned DivSteps = 48;

   // datapath micro-operations
   typedef enum logic [4:0] {
      OP_NONE  = 5'd0,
      OP_LOAD  = 5'd1,   // first step after accept
      OP_M_DTV = 5'd2,   // dt*vel
      OP_XP    = 5'd3,   // xp = pos + prod
      OP_M_DT11 = 5'd4,  // dt*c11
      OP_P01   = 5'd5,   // p01 = c01+prod, p10 = c10+prod, p11
      OP_M_DT10 = 5'd6,  // dt*c10
      OP_A00   = 5'd7,   // t = c00 + prod
      OP_M_P01 = 5'd8,   // p01*dt
      OP_P00   = 5'd9,   // p00 = t + prod + q
      OP_S     = 5'd10,  // s = p00 + r, y = z - xp
      OP_DIV0  = 5'd11,  // start k0 division
      OP_DIV1  = 5'd12,  // start k1 division
      OP_DSTEP = 5'd13,  // one divider step
      OP_K0    = 5'd14,
      OP_K1    = 5'd15,
      OP_M_K0Y = 5'd16,
      OP_POS   = 5'd17,
      OP_M_K1Y = 5'd18,
      OP_VEL   = 5'd19,
      OP_M_K0P00 = 5'd20,
      OP_C00   = 5'd21,
      OP_M_K0P01 = 5'd22,
      OP_C01   = 5'd23,
      OP_M_K1P00 = 5'd24,
      OP_C10   = 5'd25,
      OP_M_K1P01 = 5'd26,
      OP_C11   = 5'd27,
      OP_RESTART = 5'd28
   } op_type;

   typedef struct packed {
      op_type op;
      logic   load;   // input item accepted this cycle
   } cmd_type;

   typedef struct packed {
      logic s_pos;
   } stat_type;

   typedef struct packed {
      logic [30:0]        time_step;
      logic signed [31:0] noise_pos;
      logic signed [31:0] noise_vel;
      logic signed [31:0] noise_meas;
      logic signed [31:0] init_var_pos;
      logic signed [31:0] init_cov_cross;
      logic signed [31:0] init_var_vel;
   } cfg_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else if (v < -66'sh0_8000_0000) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      return sat32(66'(a) + 66'(b));
   endfunction

   function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      return sat32(66'(a) - 66'(b));
   endfunction

endpackage

@@ rtl/kfcv_datapath.sv @@
// ----------------------------------------------------------------------------
// kfcv_datapath
// State, covariance, one shared multiplier and a restoring divider.
// ----------------------------------------------------------------------------
module kfcv_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  kfcv_pkg::cmd_type     cmd,
   input  kfcv_pkg::cfg_type     cfg,
   input  logic signed [31:0]    measurement,
   output kfcv_pkg::stat_type    stat,
   output logic signed [31:0]    position,
   output logic signed [31:0]    velocity
);
   import kfcv_pkg::*;

   logic signed [31:0] pos_ff, pos_in, vel_ff, vel_in;
   logic signed [31:0] c00_ff, c00_in, c01_ff, c01_in, c10_ff, c10_in, c11_ff, c11_in;
   logic signed [31:0] z_ff, z_in, xp_ff, xp_in, p00_ff, p00_in, p01_ff, p01_in;
   logic signed [31:0] p10_ff, p10_in, p11_ff, p11_in, s_ff, s_in, y_ff, y_in;
   logic signed [31:0] t_ff, t_in, k0_ff, k0_in, k1_ff, k1_in;
   logic signed [31:0] prod_ff, prod_in;
   // divider: magnitudes, 48-bit quotient of |num|<<16 / |s|
   logic [47:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic        neg_ff, neg_in;

   logic signed [31:0] ma, mb;
   logic signed [63:0] full;
   logic signed [47:0] shr;
   logic [33:0]        trial;
   logic [31:0]        num_mag;
   logic signed [31:0] num_sel;
   logic signed [48:0] qsigned;

   always_comb begin
      ma = '0;
      mb = '0;
      unique case (cmd.op)
         OP_M_DTV:   begin ma = $signed({1'b0, cfg.time_step}); mb = vel_ff; end
         OP_M_DT11:  begin ma = $signed({1'b0, cfg.time_step}); mb = c11_ff; end
         OP_M_DT10:  begin ma = $signed({1'b0, cfg.time_step}); mb = c10_ff; end
         OP_M_P01:   begin ma = p01_ff; mb = $signed({1'b0, cfg.time_step}); end
         OP_M_K0Y:   begin ma = k0_ff; mb = y_ff; end
         OP_M_K1Y:   begin ma = k1_ff; mb = y_ff; end
         OP_M_K0P00: begin ma = k0_ff; mb = p00_ff; end
         OP_M_K0P01: begin ma = k0_ff; mb = p01_ff; end
         OP_M_K1P00: begin ma = k1_ff; mb = p00_ff; end
         OP_M_K1P01: begin ma = k1_ff; mb = p01_ff; end
         default:    begin ma = '0; mb = '0; end
      endcase
      full = ma * mb;
      // arithmetic shift floors toward minus infinity
      shr = 48'(full >>> 16);
   end

   always_comb begin
      num_sel = (cmd.op == OP_DIV1) ? p10_ff : p00_ff;
      num_mag = num_sel[31] ? 32'(-num_sel) : 32'(num_sel);
      trial = {rem_ff, quo_ff[47]} - {2'b0, s_ff};
      qsigned = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   end

   always_comb begin
      pos_in = pos_ff; vel_in = vel_ff;
      c00_in = c00_ff; c01_in = c01_ff; c10_in = c10_ff; c11_in = c11_ff;
      z_in = z_ff; xp_in = xp_ff; p00_in = p00_ff; p01_in = p01_ff;
      p10_in = p10_ff; p11_in = p11_ff; s_in = s_ff; y_in = y_ff; t_in = t_ff;
      k0_in = k0_ff; k1_in = k1_ff;
      prod_in = sat32(66'(shr));
      quo_in = quo_ff; rem_in = rem_ff; neg_in = neg_ff;
      // measurement is captured at the accepting edge
      if (cmd.load) z_in = measurement;
      unique case (cmd.op)
         OP_XP:     xp_in = qadd(pos_ff, prod_ff);
         OP_P01:    begin
            p01_in = qadd(c01_ff, prod_ff);
            p10_in = qadd(c10_ff, prod_ff);
            p11_in = qadd(c11_ff, cfg.noise_vel);
         end
         OP_A00:    t_in = qadd(c00_ff, prod_ff);
         OP_P00:    p00_in = qadd(qadd(t_ff, prod_ff), cfg.noise_pos);
         OP_S:      begin
            s_in = qadd(p00_ff, cfg.noise_meas);
            y_in = qsub(z_ff, xp_ff);
            k0_in = '0;
            k1_in = '0;
         end
         OP_DIV0, OP_DIV1: begin
            quo_in = {num_mag, 16'd0};
            rem_in = '0;
            neg_in = num_sel[31];
         end
         OP_DSTEP:  begin
            if (!trial[33]) begin
               rem_in = trial[32:0];
               quo_in = {quo_ff[46:0], 1'b1};
            end else begin
               rem_in = {rem_ff[31:0], quo_ff[47]};
               quo_in = {quo_ff[46:0], 1'b0};
            end
         end
         OP_K0:     k0_in = sat32(66'(qsigned));
         OP_K1:     k1_in = sat32(66'(qsigned));
         OP_POS:    pos_in = qadd(xp_ff, prod_ff);
         OP_VEL:    vel_in = qadd(vel_ff, prod_ff);
         OP_C00:    c00_in = qsub(p00_ff, prod_ff);
         OP_C01:    c01_in = qsub(p01_ff, prod_ff);
         OP_C10:    c10_in = qsub(p10_ff, prod_ff);
         OP_C11:    c11_in = qsub(p11_ff, prod_ff);
         OP_RESTART: begin
            pos_in = '0; vel_in = '0;
            c00_in = cfg.init_var_pos; c01_in = cfg.init_cov_cross;
            c10_in = '0; c11_in = cfg.init_var_vel;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0; vel_ff <= '0;
         c00_ff <= RST_INIT_VAR_POS; c01_ff <= RST_INIT_COV_CROSS;
         c10_ff <= '0; c11_ff <= RST_INIT_VAR_VEL;
      end else begin
         pos_ff <= pos_in; vel_ff <= vel_in;
         c00_ff <= c00_in; c01_ff <= c01_in; c10_ff <= c10_in; c11_ff <= c11_in;
      end
   end

   always_ff @(posedge clock) begin
      z_ff <= z_in; xp_ff <= xp_in; p00_ff <= p00_in; p01_ff <= p01_in;
      p10_ff <= p10_in; p11_ff <= p11_in; s_ff <= s_in; y_ff <= y_in; t_ff <= t_in;
      k0_ff <= k0_in; k1_ff <= k1_in; prod_ff <= prod_in;
      quo_ff <= quo_in; rem_ff <= rem_in; neg_ff <= neg_in;
   end

   assign stat.s_pos = (s_ff > 0);
   assign position = pos_ff;
   assign velocity = vel_ff;

endmodule

@@ rtl/kfcv_control.sv @@
// ----------------------------------------------------------------------------
// kfcv_control
// Sequencer for one filter item, plus the result register handshake.
// ----------------------------------------------------------------------------
module kfcv_control (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_action,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               degenerate,
   input  kfcv_pkg::stat_type stat,
   output kfcv_pkg::cmd_type  cmd
);
   import kfcv_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SEQ   = 6'b000010,
      ST_DIV   = 6'b000100,
      ST_TAIL  = 6'b001000,
      ST_OUT   = 6'b010000,
      ST_WAIT  = 6'b100000
   } state_type;

   state_type  state_ff, state_in;
   op_type     op_ff, op_in;
   logic [5:0] cnt_ff, cnt_in;
   logic       which_ff, which_in;
   logic       degen_ff, degen_in;
   logic       rv_ff, rv_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rv_ff;
   assign degenerate = degen_ff;

   always_comb begin
      state_in = state_ff; op_in = OP_NONE; cnt_in = cnt_ff;
      which_in = which_ff; degen_in = degen_ff; rv_in = rv_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_action) begin
                  op_in = OP_RESTART; degen_in = 1'b0; state_in = ST_OUT;
               end else begin
                  op_in = OP_LOAD; state_in = ST_SEQ;
               end
            end
         end
         ST_SEQ: begin
            unique case (op_ff)
               OP_LOAD:   op_in = OP_M_DTV;
               OP_M_DTV:  op_in = OP_XP;
               OP_XP:     op_in = OP_M_DT11;
               OP_M_DT11: op_in = OP_P01;
               OP_P01:    op_in = OP_M_DT10;
               OP_M_DT10: op_in = OP_A00;
               OP_A00:    op_in = OP_M_P01;
               OP_M_P01:  op_in = OP_P00;
               OP_P00:    op_in = OP_S;
               OP_S:      op_in = OP_NONE;   // let S settle in its register
               default:   begin
                  if (stat.s_pos) begin
                     degen_in = 1'b0; op_in = OP_DIV0; which_in = 1'b0;
                     state_in = ST_DIV; cnt_in = 6'(DivSteps);
                  end else begin
                     degen_in = 1'b1; op_in = OP_M_K0Y; state_in = ST_TAIL;
                  end
               end
            endcase
         end
         ST_DIV: begin
            if (cnt_ff != '0) begin
               op_in = OP_DSTEP; cnt_in = cnt_ff - 6'd1;
            end else if (!which_ff) begin
               if (op_ff == OP_K0) begin
                  op_in = OP_DIV1; which_in = 1'b1; cnt_in = 6'(DivSteps);
               end else begin
                  op_in = OP_K0;
               end
            end else begin
               if (op_ff == OP_K1) begin
                  op_in = OP_M_K0Y; state_in = ST_TAIL;
               end else begin
                  op_in = OP_K1;
               end
            end
         end
         ST_TAIL: begin
            unique case (op_ff)
               OP_M_K0Y:   op_in = OP_POS;
               OP_POS:     op_in = OP_M_K1Y;
               OP_M_K1Y:   op_in = OP_VEL;
               OP_VEL:     op_in = OP_M_K0P00;
               OP_M_K0P00: op_in = OP_C00;
               OP_C00:     op_in = OP_M_K0P01;
               OP_M_K0P01: op_in = OP_C01;
               OP_C01:     op_in = OP_M_K1P00;
               OP_M_K1P00: op_in = OP_C10;
               OP_C10:     op_in = OP_M_K1P01;
               OP_M_K1P01: op_in = OP_C11;
               default:    state_in = ST_OUT;
            endcase
         end
         ST_OUT: begin
            rv_in = 1'b1; state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (rsp_ready) begin
               rv_in = 1'b0; state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; op_ff <= OP_NONE; cnt_ff <= '0;
         which_ff <= 1'b0; degen_ff <= 1'b0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; op_ff <= op_in; cnt_ff <= cnt_in;
         which_ff <= which_in; degen_ff <= degen_in; rv_ff <= rv_in;
      end
   end

   assign cmd = '{op: op_ff, load: (req_valid && req_ready)};

   a_valid_in_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == ST_WAIT) else $error("result valid outside wait");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("ready while result pending");
   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> cnt_ff <= 6'(DivSteps)) else $error("divider count");

endmodule

@@ rtl/kfcv_csr.sv @@
// ----------------------------------------------------------------------------
// kfcv_csr
// APB register file for filter configuration.
// ----------------------------------------------------------------------------
module kfcv_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [kfcv_pkg::AddrWidth-1:0]  paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output kfcv_pkg::cfg_type               cfg
);
   import kfcv_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    wr;

   assign wr = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (paddr)
            ADDR_TIME_STEP:      cfg_in.time_step = pwdata[30:0];
            ADDR_NOISE_POS:      cfg_in.noise_pos = pwdata;
            ADDR_NOISE_VEL:      cfg_in.noise_vel = pwdata;
            ADDR_NOISE_MEAS:     cfg_in.noise_meas = pwdata;
            ADDR_INIT_VAR_POS:   cfg_in.init_var_pos = pwdata;
            ADDR_INIT_COV_CROSS: cfg_in.init_cov_cross = pwdata;
            ADDR_INIT_VAR_VEL:   cfg_in.init_var_vel = pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr)
         ADDR_TIME_STEP:      prdata = {1'b0, cfg_ff.time_step};
         ADDR_NOISE_POS:      prdata = cfg_ff.noise_pos;
         ADDR_NOISE_VEL:      prdata = cfg_ff.noise_vel;
         ADDR_NOISE_MEAS:     prdata = cfg_ff.noise_meas;
         ADDR_INIT_VAR_POS:   prdata = cfg_ff.init_var_pos;
         ADDR_INIT_COV_CROSS: prdata = cfg_ff.init_cov_cross;
         ADDR_INIT_VAR_VEL:   prdata = cfg_ff.init_var_vel;
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{RST_TIME_STEP, RST_NOISE_POS, RST_NOISE_VEL, RST_NOISE_MEAS,
                     RST_INIT_VAR_POS, RST_INIT_COV_CROSS, RST_INIT_VAR_VEL};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/kalman_filter_const_velocity.sv @@
// ----------------------------------------------------------------------------
// kalman_filter_const_velocity
// Two-state constant-velocity Kalman filter, Q16.16, APB configuration.
// ----------------------------------------------------------------------------
// Sequence: an update item runs the prediction, two 48-step restoring divisions
//   for the gains (skipped when S is not positive) and the correction; a restart
//   item only reloads state and covariance.
// Throughput: one item at a time; the next item is accepted at the earliest in
//   the cycle after the result is taken.
// Reset: synchronous; state zero, covariance and registers at reset values.
module kalman_filter_const_velocity (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_action,
   input  logic signed [31:0]             req_measurement,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [31:0]             rsp_position_estimate,
   output logic signed [31:0]             rsp_velocity_estimate,
   output logic                           rsp_degenerate,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [kfcv_pkg::AddrWidth-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);
   import kfcv_pkg::*;

   cfg_type  cfg;
   cmd_type  cmd;
   stat_type stat;

   assign csr_pready = 1'b1;

   kfcv_csr u_csr (
      .clock, .reset,
      .psel(csr_psel), .penable(csr_penable), .pwrite(csr_pwrite),
      .paddr(csr_paddr), .pwdata(csr_pwdata), .prdata(csr_prdata), .cfg
   );

   kfcv_control u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_action,
      .rsp_valid, .rsp_ready, .degenerate(rsp_degenerate), .stat, .cmd
   );

   kfcv_datapath u_dp (
      .clock, .reset, .cmd, .cfg, .measurement(req_measurement), .stat,
      .position(rsp_position_estimate), .velocity(rsp_velocity_estimate)
   );

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the constant-velocity Kalman filter: a bit-exact
// Q16.16 predictor tracks state and covariance, results are checked in order.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import kfcv_pkg::*;

   localparam int unsigned CycleLimit = 1500000;
   localparam logic ACT_UPDATE = 1'b0;
   localparam logic ACT_RESTART = 1'b1;

   typedef struct {
      logic signed [31:0] pos;
      logic signed [31:0] vel;
      logic               degen;
   } estimate_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_action = 1'b0;
   logic signed [31:0] req_measurement = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_position_estimate;
   logic signed [31:0] rsp_velocity_estimate;
   logic rsp_degenerate;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [AddrWidth-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   kalman_filter_const_velocity uut (.*);

   always #5 clock = ~clock;

   // filter state as the predictor sees it
   cfg_type            cfg_shadow;
   logic signed [31:0] pos_est, vel_est, cov00, cov01, cov10, cov11;
   estimate_type       pending_estimates[$];
   int unsigned        errors = 0;
   int unsigned        cycles = 0;
   bit                 quiet = 1'b0;
   logic signed [31:0] track_pos = '0;
   logic signed [31:0] track_vel = 32'sd65536;

   function automatic logic signed [31:0] clip(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] fx_add(input logic signed [31:0] a, b);
      return clip(longint'(a) + longint'(b));
   endfunction

   function automatic logic signed [31:0] fx_sub(input logic signed [31:0] a, b);
      return clip(longint'(a) - longint'(b));
   endfunction

   // >>> on a signed product floors toward minus infinity
   function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a, b);
      return clip((longint'(a) * longint'(b)) >>> 16);
   endfunction

   function automatic logic signed [31:0] fx_div(input logic signed [31:0] n, d);
      return clip((longint'(n) * 64'sd65536) / longint'(d));
   endfunction

   function automatic estimate_type filter_step(input logic act,
                                                input logic signed [31:0] z);
      estimate_type       e;
      logic signed [31:0] dt, xp, vp, p00, p01, p10, p11, s, k0, k1, innov;
      e.degen = 1'b0;
      if (act == ACT_RESTART) begin
         pos_est = '0;
         vel_est = '0;
         cov00 = cfg_shadow.init_var_pos;
         cov01 = cfg_shadow.init_cov_cross;
         cov10 = '0;
         cov11 = cfg_shadow.init_var_vel;
      end else begin
         dt = signed'({1'b0, cfg_shadow.time_step});
         xp = fx_add(pos_est, fx_mul(dt, vel_est));
         vp = vel_est;
         p01 = fx_add(cov01, fx_mul(dt, cov11));
         p00 = fx_add(fx_add(fx_add(cov00, fx_mul(dt, cov10)), fx_mul(p01, dt)),
                      cfg_shadow.noise_pos);
         p10 = fx_add(cov10, fx_mul(dt, cov11));
         p11 = fx_add(cov11, cfg_shadow.noise_vel);
         s = fx_add(p00, cfg_shadow.noise_meas);
         if (s > 0) begin
            k0 = fx_div(p00, s);
            k1 = fx_div(p10, s);
         end else begin
            k0 = '0;
            k1 = '0;
            e.degen = 1'b1;
         end
         innov = fx_sub(z, xp);
         pos_est = fx_add(xp, fx_mul(k0, innov));
         vel_est = fx_add(vp, fx_mul(k1, innov));
         cov00 = fx_sub(p00, fx_mul(k0, p00));
         cov01 = fx_sub(p01, fx_mul(k0, p01));
         cov10 = fx_sub(p10, fx_mul(k1, p00));
         cov11 = fx_sub(p11, fx_mul(k1, p01));
      end
      e.pos = pos_est;
      e.vel = vel_est;
      return e;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_ready <= quiet || ($urandom_range(99) >= 16);

   always @(posedge clock) begin
      estimate_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_estimates.size() == 0) begin
            errors++;
            $display("%0t: unexpected result pos=%0d vel=%0d", $time,
                     rsp_position_estimate, rsp_velocity_estimate);
         end else begin
            e = pending_estimates.pop_front();
            if (rsp_position_estimate !== e.pos) begin
               errors++;
               $display("%0t: position expected %0d got %0d", $time, e.pos,
                        rsp_position_estimate);
            end
            if (rsp_velocity_estimate !== e.vel) begin
               errors++;
               $display("%0t: velocity expected %0d got %0d", $time, e.vel,
                        rsp_velocity_estimate);
            end
            if (rsp_degenerate !== e.degen) begin
               errors++;
               $display("%0t: degenerate expected %0b got %0b", $time, e.degen,
                        rsp_degenerate);
            end
         end
      end
   end

   task automatic send_item(input logic act, input logic signed [31:0] z);
      @(negedge clock);
      while (!quiet && $urandom_range(99) < 16) @(negedge clock);
      req_valid <= 1'b1;
      req_action <= act;
      req_measurement <= z;
      do @(posedge clock); while (!req_ready);
      pending_estimates.push_back(filter_step(act, z));
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic drain;
      wait (pending_estimates.size() == 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_write(input logic [AddrWidth-1:0] addr, input logic [31:0] data);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (addr)
         ADDR_TIME_STEP:      cfg_shadow.time_step = data[30:0];
         ADDR_NOISE_POS:      cfg_shadow.noise_pos = data;
         ADDR_NOISE_VEL:      cfg_shadow.noise_vel = data;
         ADDR_NOISE_MEAS:     cfg_shadow.noise_meas = data;
         ADDR_INIT_VAR_POS:   cfg_shadow.init_var_pos = data;
         ADDR_INIT_COV_CROSS: cfg_shadow.init_cov_cross = data;
         ADDR_INIT_VAR_VEL:   cfg_shadow.init_var_vel = data;
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [31:0] dt, qp, qv, r, ip, ic, iv);
      drain();
      csr_write(ADDR_TIME_STEP, dt);
      csr_write(ADDR_NOISE_POS, qp);
      csr_write(ADDR_NOISE_VEL, qv);
      csr_write(ADDR_NOISE_MEAS, r);
      csr_write(ADDR_INIT_VAR_POS, ip);
      csr_write(ADDR_INIT_COV_CROSS, ic);
      csr_write(ADDR_INIT_VAR_VEL, iv);
   endtask

   task automatic test_reset_defaults;
      send_item(ACT_UPDATE, 32'sd0);
      send_item(ACT_UPDATE, 32'sh7FFF_FFFF);
      send_item(ACT_UPDATE, 32'sh8000_0000);
      send_item(ACT_UPDATE, -32'sd1);
      send_item(ACT_RESTART, 32'sh7FFF_FFFF);
      send_item(ACT_UPDATE, 32'sd65536);
      send_item(ACT_UPDATE, 32'sd131072);
      send_item(ACT_RESTART, $urandom);
   endtask

   // S <= 0: gains forced to zero, state follows the prediction
   task automatic test_degenerate;
      write_all(32'd65536, 32'h8000_0000, 32'd100, 32'h8000_0000,
                32'd0, 32'd0, 32'd65536);
      send_item(ACT_RESTART, 32'sd0);
      send_item(ACT_UPDATE, 32'sd12345);
      send_item(ACT_UPDATE, 32'sh8000_0000);
      send_item(ACT_UPDATE, 32'sh7FFF_FFFF);
   endtask

   task automatic test_extremes;
      write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_item(ACT_RESTART, 32'sd0);
      send_item(ACT_UPDATE, 32'sh8000_0000);
      send_item(ACT_UPDATE, 32'sh7FFF_FFFF);
      write_all(32'd0, 32'h8000_0000, 32'h8000_0000, 32'd1,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_item(ACT_RESTART, 32'sd0);
      send_item(ACT_UPDATE, 32'sh7FFF_FFFF);
      send_item(ACT_UPDATE, -32'sd65536);
   endtask

   task automatic test_random_tracking(input int phases, input int per_phase);
      logic [31:0] dt, qp, qv, r, ip, ic, iv;
      logic signed [31:0] z;
      for (int ph = 0; ph < phases; ph++) begin
         // mostly realistic tuning, sometimes anything goes
         if ($urandom_range(3) == 0) begin
            dt = $urandom; qp = $urandom; qv = $urandom; r = $urandom;
            ip = $urandom; ic = $urandom; iv = $urandom;
         end else begin
            dt = $urandom_range(131072);
            qp = $urandom_range(65536);
            qv = $urandom_range(65536);
            r = $urandom_range(1, 1 << 20);
            ip = $urandom_range(1 << 20);
            ic = $signed($urandom_range(1 << 16)) - 32768;
            iv = $urandom_range(1 << 20);
         end
         write_all(dt, qp, qv, r, ip, ic, iv);
         quiet = (ph == 2);
         track_pos = '0;
         track_vel = $signed($urandom_range(1 << 18)) - (1 << 17);
         send_item(ACT_RESTART, $urandom);
         for (int i = 0; i < per_phase; i++) begin
            if ($urandom_range(99) < 4) begin
               send_item(ACT_RESTART, $urandom);
               track_pos = '0;
            end else begin
               track_pos = track_pos + track_vel;
               z = track_pos + ($signed($urandom_range(8191)) - 4096);
               if ($urandom_range(9) == 0) z = $urandom;
               send_item(ACT_UPDATE, z);
            end
         end
         quiet = 1'b0;
      end
   endtask

   initial begin
      cfg_shadow = '{RST_TIME_STEP, RST_NOISE_POS, RST_NOISE_VEL, RST_NOISE_MEAS,
                     RST_INIT_VAR_POS, RST_INIT_COV_CROSS, RST_INIT_VAR_VEL};
      pos_est = '0;
      vel_est = '0;
      cov00 = RST_INIT_VAR_POS;
      cov01 = RST_INIT_COV_CROSS;
      cov10 = '0;
      cov11 = RST_INIT_VAR_VEL;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_degenerate();
      test_extremes();
      test_random_tracking(8, 210);
      drain();
      repeat (200) @(negedge clock);
      if (errors == 0 && pending_estimates.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/kfcv_pkg.sv
rtl/kfcv_datapath.sv
rtl/kfcv_control.sv
rtl/kfcv_csr.sv
rtl/kalman_filter_const_velocity.sv
sim/tb.sv
